// ===== rtl/dtt_pkg.sv =====
package dtt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] FuncAdd    = 2'd0;
  localparam logic [1:0] FuncCancel = 2'd1;
  localparam logic [1:0] FuncTick   = 2'd2;
  localparam logic [1:0] FuncSpare  = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StFull    = 3'd1;
  localparam logic [2:0] StMissing = 3'd2;
  localparam logic [2:0] StFired   = 3'd3;
  localparam logic [2:0] StNone    = 3'd4;

  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  // One stored timer: id, deadline and period.
  localparam int EntryW = 16 + 48 + 32;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] tid;
    logic [47:0] deadline;
    logic [31:0] repeat_interval;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fired_id;
    logic        is_earliest;
    logic [47:0] next_deadline;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [47:0] deadline;
    logic [31:0] period;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_ADD_WR,
    S_SEL,
    S_SEL_WAIT,
    S_FIRE,
    S_NEXT,
    S_NEXT_WAIT,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/dtt_ram.sv =====
module dtt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/deadline_timer_table_unit.sv =====
// Timer table of dtt_pkg::TableDepth entries kept in one synchronous RAM with a
// valid bit per entry in flip-flops. Every walk of the table reads one entry a
// cycle. An add or cancel walks the table twice, once to find the id and a free
// slot and once for the earliest remaining deadline, and gives a single result.
// A tick walks the table once per fired timer to pick the next by (deadline,
// id), plus one more pass that finds nothing unless all TableDepth timers
// fired, and then walks it once more for the minimum before the first result;
// each further result follows one a cycle while out_ready stays high. The
// single RAM read port is why the walks run one after another. A result waits
// in an output register; the block goes back to idle and takes the next
// transfer while it waits, and stalls only when a new result is ready before
// the old one has left. Up to TableDepth timers fire on one tick.
module deadline_timer_table_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtt_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dtt_pkg::rsp_t out_data
);

  localparam int IW = dtt_pkg::IdxW;
  localparam int CW = dtt_pkg::CntW;
  localparam logic [IW-1:0] LastIdx = IW'(dtt_pkg::TableDepth - 1);

  dtt_pkg::state_t state, state_next;
  dtt_pkg::req_t   req;

  logic [dtt_pkg::TableDepth-1:0] valid_bits;
  logic [dtt_pkg::TableDepth-1:0] taken;

  // RAM ports.
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  dtt_pkg::entry_t       ram_wdata, ram_rdata;

  // Walk bookkeeping.
  logic [IW-1:0] rd_idx;    // address being issued
  logic [IW-1:0] cmp_idx;   // address whose data is on rdata
  logic          cmp_live;
  logic          rd_done;

  // Add/cancel walk results.
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;

  // Selection walk results.
  logic            best_found;
  logic [IW-1:0]   best_idx;
  logic [47:0]     best_dl;
  logic [15:0]     best_id;
  logic [31:0]     best_per;

  // Minimum deadline over valid entries.
  logic            min_found;
  logic [47:0]     min_dl;

  // Fired list.
  logic [15:0]   fired [dtt_pkg::TableDepth];
  logic [CW-1:0] n_fired;
  logic [CW-1:0] emit_k;

  logic          out_full;
  logic          out_load;
  dtt_pkg::rsp_t out_reg;
  dtt_pkg::rsp_t rsp_first;

  dtt_ram #(.Width(dtt_pkg::EntryW), .Depth(dtt_pkg::TableDepth)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state == dtt_pkg::S_IDLE);
  assign out_valid = out_full;
  assign out_data  = out_reg;
  assign ram_raddr = rd_idx;

  // A result enters the output register when it is empty or being emptied.
  assign out_load = ((state == dtt_pkg::S_NEXT_WAIT) || (state == dtt_pkg::S_EMIT)) &&
                    (!out_full || out_ready);

  // Current entry under comparison is live and valid.
  logic cur_ok;
  assign cur_ok = cmp_live && valid_bits[cmp_idx];

  // Re-armed deadline with saturation.
  logic [48:0] rearm_sum;
  logic [47:0] rearm_dl;
  assign rearm_sum = {1'b0, req.now_ms} + {17'd0, best_per};
  assign rearm_dl  = rearm_sum[48] ? dtt_pkg::Max48 : rearm_sum[47:0];

  // Slot chosen for an add.
  logic          add_ok;
  logic [IW-1:0] add_slot;
  assign add_ok   = hit_found || free_found;
  assign add_slot = hit_found ? hit_idx : free_idx;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dtt_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.func == dtt_pkg::FuncTick) begin
            state_next = dtt_pkg::S_SEL;
          end else begin
            state_next = dtt_pkg::S_SCAN;
          end
        end
      end
      dtt_pkg::S_SCAN:      if (rd_done) state_next = dtt_pkg::S_SCAN_WAIT;
      dtt_pkg::S_SCAN_WAIT: begin
        if (req.func == dtt_pkg::FuncAdd && add_ok) begin
          state_next = dtt_pkg::S_ADD_WR;
        end else begin
          state_next = dtt_pkg::S_NEXT;
        end
      end
      dtt_pkg::S_ADD_WR:    state_next = dtt_pkg::S_NEXT;
      dtt_pkg::S_SEL:       if (rd_done) state_next = dtt_pkg::S_SEL_WAIT;
      dtt_pkg::S_SEL_WAIT:  state_next = dtt_pkg::S_FIRE;
      dtt_pkg::S_FIRE: begin
        if (!best_found || n_fired == CW'(dtt_pkg::TableDepth - 1)) begin
          state_next = dtt_pkg::S_NEXT;
        end else begin
          state_next = dtt_pkg::S_SEL;
        end
      end
      dtt_pkg::S_NEXT:      if (rd_done) state_next = dtt_pkg::S_NEXT_WAIT;
      dtt_pkg::S_NEXT_WAIT: begin
        if (!out_full || out_ready) begin
          if (req.func == dtt_pkg::FuncTick && n_fired > CW'(1)) begin
            state_next = dtt_pkg::S_EMIT;
          end else begin
            state_next = dtt_pkg::S_IDLE;
          end
        end
      end
      dtt_pkg::S_EMIT: begin
        if ((!out_full || out_ready) && emit_k == n_fired - CW'(1)) begin
          state_next = dtt_pkg::S_IDLE;
        end
      end
      default: state_next = dtt_pkg::S_IDLE;
    endcase
  end

  // RAM write control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = add_slot;
    ram_wdata = '{id: req.tid, deadline: req.deadline, period: req.repeat_interval};
    case (state)
      dtt_pkg::S_ADD_WR: ram_we = 1'b1;
      dtt_pkg::S_FIRE: begin
        ram_waddr = best_idx;
        ram_wdata = '{id: best_id, deadline: rearm_dl, period: best_per};
        ram_we    = best_found && (best_per != 32'd0);
      end
      default: ram_we = 1'b0;
    endcase
  end

  // First result of an operation, formed once the minimum walk is done.
  always_comb begin
    rsp_first               = '0;
    rsp_first.next_deadline = min_found ? min_dl : 48'd0;
    rsp_first.last          = 1'b1;
    case (req.func)
      dtt_pkg::FuncAdd: begin
        rsp_first.status      = add_ok ? dtt_pkg::StOk : dtt_pkg::StFull;
        rsp_first.is_earliest = add_ok && !best_found;
      end
      dtt_pkg::FuncCancel: begin
        rsp_first.status = hit_found ? dtt_pkg::StOk : dtt_pkg::StMissing;
      end
      dtt_pkg::FuncTick: begin
        if (n_fired == '0) begin
          rsp_first.status = dtt_pkg::StNone;
        end else begin
          rsp_first.status   = dtt_pkg::StFired;
          rsp_first.fired_id = fired[0];
          rsp_first.last     = (n_fired == CW'(1));
        end
      end
      default: rsp_first.status = dtt_pkg::StOk;
    endcase
  end

  logic walking;
  assign walking = (state == dtt_pkg::S_SCAN) || (state == dtt_pkg::S_SEL) ||
                   (state == dtt_pkg::S_NEXT);

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dtt_pkg::S_IDLE;
      valid_bits <= '0;
      out_full   <= 1'b0;
      cmp_live   <= 1'b0;
      rd_idx     <= '0;
      rd_done    <= 1'b0;
      n_fired    <= '0;
    end else begin
      state    <= state_next;
      out_full <= out_load || (out_full && !out_ready);

      // Address walk: one read a cycle, data compared in the next cycle.
      cmp_live <= walking && !rd_done;
      cmp_idx  <= rd_idx;
      if (walking && !rd_done) begin
        rd_idx  <= rd_idx + IW'(1);
        rd_done <= (rd_idx == LastIdx);
      end else if (!walking) begin
        rd_idx  <= '0;
        rd_done <= 1'b0;
      end

      case (state)
        dtt_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            req        <= in_data;
            taken      <= '0;
            n_fired    <= '0;
            emit_k     <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            min_found  <= 1'b0;
          end
        end
        dtt_pkg::S_SCAN, dtt_pkg::S_SCAN_WAIT: begin
          if (cur_ok && ram_rdata.id == req.tid && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
          end
          if (cmp_live && !valid_bits[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (state == dtt_pkg::S_SCAN_WAIT && req.func == dtt_pkg::FuncCancel
              && hit_found) begin
            valid_bits[hit_idx] <= 1'b0;
          end
        end
        dtt_pkg::S_ADD_WR: begin
          valid_bits[add_slot] <= 1'b1;
        end
        dtt_pkg::S_SEL, dtt_pkg::S_SEL_WAIT: begin
          if (cur_ok && !taken[cmp_idx] && ram_rdata.deadline <= req.now_ms &&
              (!best_found || ram_rdata.deadline < best_dl ||
               (ram_rdata.deadline == best_dl && ram_rdata.id < best_id))) begin
            best_found <= 1'b1;
            best_idx   <= cmp_idx;
            best_dl    <= ram_rdata.deadline;
            best_id    <= ram_rdata.id;
            best_per   <= ram_rdata.period;
          end
        end
        dtt_pkg::S_FIRE: begin
          best_found <= 1'b0;
          if (best_found) begin
            taken[best_idx]  <= 1'b1;
            fired[n_fired[IW-1:0]] <= best_id;
            n_fired          <= n_fired + CW'(1);
            if (best_per == 32'd0) valid_bits[best_idx] <= 1'b0;
          end
        end
        dtt_pkg::S_NEXT: begin
          // Minimum over valid entries; on add also tracks others for is_earliest.
          if (cur_ok && (!min_found || ram_rdata.deadline < min_dl)) begin
            min_found <= 1'b1;
            min_dl    <= ram_rdata.deadline;
          end
          if (cur_ok && req.func == dtt_pkg::FuncAdd && cmp_idx != add_slot &&
              ram_rdata.deadline <= req.deadline) begin
            best_found <= 1'b1;
          end
        end
        dtt_pkg::S_NEXT_WAIT: begin
          if (out_load) begin
            out_reg <= rsp_first;
            emit_k  <= CW'(1);
          end
        end
        dtt_pkg::S_EMIT: begin
          if (out_load) begin
            out_reg.status   <= dtt_pkg::StFired;
            out_reg.fired_id <= fired[emit_k[IW-1:0]];
            out_reg.last     <= (emit_k == n_fired - CW'(1));
            emit_k           <= emit_k + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != dtt_pkg::S_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
  a_fired_bound: assert property (@(posedge clk) disable iff (rst)
    n_fired <= CW'(dtt_pkg::TableDepth))
    else $error("fired count overflow");

endmodule
